// File: hw/rtl/dgp_pkg.sv
// Shared constants and types for the DPCM / GAP pixel predictor.
package dgp_pkg;

   // line store geometry
   localparam int MAX_WIDTH = 4096;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int POS_W     = $clog2(MAX_WIDTH + 1);

   // configuration register fields
   localparam int CFG_RULE_W   = 3;
   localparam int CFG_WIDTH_W  = 13;
   localparam int CFG_HEIGHT_W = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int CMP_W        = (POS_W > CFG_WIDTH_W) ? POS_W : CFG_WIDTH_W;
   localparam int MIN_WIDTH    = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_RULE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [CFG_RULE_W-1:0] RULE_WEST  = 3'd1;
   localparam logic [CFG_RULE_W-1:0] RULE_NORTH = 3'd2;
   localparam logic [CFG_RULE_W-1:0] RULE_HALF  = 3'd3;
   localparam logic [CFG_RULE_W-1:0] RULE_CALIC = 3'd4;

   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 13'd256;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd256;

   localparam int ROW_W = 16;

   // prediction constants
   localparam logic [7:0]        PRED_ORIGIN = 8'd128;
   localparam logic signed [10:0] GAP_SHARP  = 11'sd80;
   localparam logic signed [10:0] GAP_MID    = 11'sd32;
   localparam logic signed [10:0] GAP_SOFT   = 11'sd8;

   // result kinds
   localparam logic [1:0] KIND_RESIDUAL = 2'd0;
   localparam logic [1:0] KIND_BINARY   = 2'd1;
   localparam logic [1:0] KIND_ESCAPE   = 2'd2;

   // result queue
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic signed [8:0] value;
      logic [1:0]        kind;
      logic              last_of_pixel;
      logic              end_of_image;
   } result_type;

endpackage

// File: hw/rtl/dgp_ram.sv
// Generic RAM: one write port, two registered read ports with shared enable.
module dgp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: hw/rtl/dpcm_gap_pixel_predictor_core.sv
// DPCM pixel predictor core with CALIC binary mode and GAP prediction.
// Results are queued when their pixel is accepted and presented on rsp_* from the queue head.
// Throughput: one pixel per cycle while req_stall is low; an escape pixel gives two
//   results and the 4-entry result queue drains one per cycle while rsp_stall is low.
// After reset and after every register write req_stall is high for one cycle
//   while the line-store read for the current position is refreshed.
// Reset (synchronous) clears position, W/WW/NW and sets registers to defaults;
//   line stores are not cleared.
module dpcm_gap_pixel_predictor_core (
   input  logic                               clock,
   input  logic                               reset,
   // pixel input
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_pixel,
   // result output
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [8:0]                  rsp_value,
   output logic [1:0]                         rsp_kind,
   output logic                               rsp_last_of_pixel,
   output logic                               rsp_end_of_image,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dgp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dgp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = dgp_pkg::ADDR_W;
   localparam int PW = dgp_pkg::POS_W;
   localparam int CW = dgp_pkg::CMP_W;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [dgp_pkg::CFG_RULE_W-1:0]   rule_ff;
   logic [dgp_pkg::CFG_WIDTH_W-1:0]  width_ff;
   logic [dgp_pkg::CFG_HEIGHT_W-1:0] height_ff;
   logic                             csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff   <= dgp_pkg::RULE_WEST;
         width_ff  <= dgp_pkg::WIDTH_RESET;
         height_ff <= dgp_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            dgp_pkg::CSR_RULE:   rule_ff   <= csr_wdata[dgp_pkg::CFG_RULE_W-1:0];
            dgp_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[dgp_pkg::CFG_WIDTH_W-1:0];
            dgp_pkg::CSR_HEIGHT: height_ff <= csr_wdata[dgp_pkg::CFG_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // effective image size: width clamped to 3..MAX_WIDTH, height 0 acts as 1
   logic [CW-1:0] width_raw;
   logic [CW-1:0] width_clamp;
   logic [PW-1:0] wid;
   logic [dgp_pkg::CFG_HEIGHT_W-1:0] hgt;

   always_comb begin
      width_raw = CW'(width_ff);
      if (width_raw < CW'(dgp_pkg::MIN_WIDTH)) begin
         width_clamp = CW'(dgp_pkg::MIN_WIDTH);
      end else if (width_raw > CW'(dgp_pkg::MAX_WIDTH)) begin
         width_clamp = CW'(dgp_pkg::MAX_WIDTH);
      end else begin
         width_clamp = width_raw;
      end
      wid = PW'(width_clamp);
      hgt = (height_ff == '0) ? dgp_pkg::CFG_HEIGHT_W'(1) : height_ff;
   end

   // ---------------------------------------------------------------------
   // position, neighbor registers, handshake
   // ---------------------------------------------------------------------
   logic [AW-1:0]             column_ff, column_in;
   logic [dgp_pkg::ROW_W-1:0] row_ff, row_in;
   logic [7:0]                w_ff, ww_ff, nw_ff;
   // line-store read data matches the current position only when set
   logic                      fetch_ok_ff, fetch_ok_in;

   logic [dgp_pkg::OUT_CNT_W-1:0] count_ff, count_in;
   logic [dgp_pkg::OUT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dgp_pkg::OUT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   dgp_pkg::result_type           queue_ff [dgp_pkg::OUT_DEPTH];

   logic accept;
   logic pop;

   // room for two results keeps an escape pixel from overflowing the queue
   assign req_stall = !fetch_ok_ff ||
                      (count_ff > dgp_pkg::OUT_CNT_W'(dgp_pkg::OUT_DEPTH - 2));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;

   // current column, clamped when the width shrank under it
   logic [AW-1:0] col;
   logic          last_col;
   logic          end_img;
   logic [AW-1:0] next_col;

   always_comb begin
      col      = (PW'(column_ff) >= wid) ? AW'(wid - PW'(1)) : column_ff;
      last_col = ((PW'(col) + PW'(1)) == wid);
      end_img  = last_col &&
                 (({1'b0, row_ff} + (dgp_pkg::ROW_W + 1)'(1)) >= {1'b0, hgt});
      next_col = last_col ? '0 : col + AW'(1);
   end

   // ---------------------------------------------------------------------
   // line stores: read N/NN at the next position (the current one on a refresh) and NE/NNE one past it
   // ---------------------------------------------------------------------
   logic          rd_en;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   logic [7:0]    above_a, above_b, two_a, two_b;

   assign rd_en     = accept || !fetch_ok_ff;
   assign rd_addr_a = fetch_ok_ff ? next_col : col;
   assign rd_addr_b = rd_addr_a + AW'(1);

   dgp_ram #(
      .WIDTH (8),
      .DEPTH (dgp_pkg::MAX_WIDTH)
   ) u_row_above (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (col),
      .wr_data   (req_pixel),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (above_a),
      .rd_data_b (above_b)
   );

   dgp_ram #(
      .WIDTH (8),
      .DEPTH (dgp_pkg::MAX_WIDTH)
   ) u_row_two_above (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (col),
      .wr_data   (above_a),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (two_a),
      .rd_data_b (two_b)
   );

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------
   function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
      absd = (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [8:0] resid(input logic [7:0] x, input logic [7:0] p);
      resid = {1'b0, x} - {1'b0, p};
   endfunction

   logic [7:0] x, w, ww, n, nw, ne, nn, nne;

   assign x   = req_pixel;
   assign w   = w_ff;
   assign ww  = ww_ff;
   assign nw  = nw_ff;
   assign n   = above_a;
   assign nn  = two_a;
   assign ne  = last_col ? 8'd0 : above_b;
   assign nne = last_col ? 8'd0 : two_b;

   // GAP predictor
   logic [9:0]         dh, dv;
   logic signed [10:0] dvh;
   logic [7:0]         avg;
   logic [8:0]         ne_nw, ne_nw_adj;
   logic [6:0]         q4;
   logic [9:0]         p0;
   logic [10:0]        s2w, s2n, s2;
   logic [10:0]        s2_adj;
   logic [11:0]        s3w, s3n, s3, s3_adj;
   logic [9:0]         pg;
   logic [7:0]         gap_pred;

   always_comb begin
      dh  = 10'(absd(w, ww)) + 10'(absd(n, nw)) + 10'(absd(ne, n));
      dv  = 10'(absd(w, nw)) + 10'(absd(n, nn)) + 10'(absd(ne, nne));
      dvh = $signed({1'b0, dv}) - $signed({1'b0, dh});

      avg       = 8'(({1'b0, w} + {1'b0, n}) >> 1);
      ne_nw     = {1'b0, ne} - {1'b0, nw};
      // quarter, truncated toward zero
      ne_nw_adj = ne_nw + (ne_nw[8] ? 9'd3 : 9'd0);
      q4        = ne_nw_adj[8:2];
      p0        = {2'b00, avg} + {{3{q4[6]}}, q4};

      s2w = {p0[9], p0} + {3'b000, w};
      s2n = {p0[9], p0} + {3'b000, n};
      s3w = {{2{p0[9]}}, p0} + {p0[9], p0, 1'b0} + {4'b0000, w};
      s3n = {{2{p0[9]}}, p0} + {p0[9], p0, 1'b0} + {4'b0000, n};
      s2  = (dvh > dgp_pkg::GAP_MID) ? s2w : s2n;
      s3  = (dvh > dgp_pkg::GAP_SOFT) ? s3w : s3n;
      s2_adj = s2 + (s2[10] ? 11'd1 : 11'd0);
      s3_adj = s3 + (s3[11] ? 12'd3 : 12'd0);

      if (dvh > dgp_pkg::GAP_SHARP) begin
         pg = {2'b00, w};
      end else if (dvh < -dgp_pkg::GAP_SHARP) begin
         pg = {2'b00, n};
      end else if ((dvh > dgp_pkg::GAP_MID) || (dvh < -dgp_pkg::GAP_MID)) begin
         pg = s2_adj[10:1];
      end else if ((dvh > dgp_pkg::GAP_SOFT) || (dvh < -dgp_pkg::GAP_SOFT)) begin
         pg = s3_adj[11:2];
      end else begin
         pg = p0;
      end

      if (pg[9]) begin
         gap_pred = 8'd0;
      end else if (pg[8]) begin
         gap_pred = 8'd255;
      end else begin
         gap_pred = pg[7:0];
      end
   end

   // binary mode test over the seven neighbors
   logic [7:0] nb [7];
   logic [7:0] s1;
   logic       have_s1;
   logic       binary;

   always_comb begin
      nb[0] = w;  nb[1] = ww; nb[2] = n;  nb[3] = nw;
      nb[4] = ne; nb[5] = nn; nb[6] = nne;
      s1      = 8'd0;
      have_s1 = 1'b0;
      // lowest index that differs from W wins
      for (int k = 6; k >= 1; k--) begin
         if (nb[k] != w) begin
            s1      = nb[k];
            have_s1 = 1'b1;
         end
      end
      binary = 1'b1;
      for (int k = 1; k < 7; k++) begin
         if ((nb[k] != w) && (nb[k] != s1)) begin
            binary = 1'b0;
         end
      end
   end

   // result selection
   dgp_pkg::result_type r0, r1;
   logic                push_two;

   always_comb begin
      r0.value         = '0;
      r0.kind          = dgp_pkg::KIND_RESIDUAL;
      r0.last_of_pixel = 1'b1;
      r0.end_of_image  = end_img;
      r1               = r0;
      push_two         = 1'b0;

      if (row_ff == '0) begin
         r0.value = $signed(resid(x, (col == '0) ? dgp_pkg::PRED_ORIGIN : w));
      end else if ((row_ff == dgp_pkg::ROW_W'(1)) || (col < AW'(2)) || last_col) begin
         r0.value = $signed(resid(x, n));
      end else begin
         case (rule_ff)
            dgp_pkg::RULE_NORTH: begin
               r0.value = $signed(resid(x, n));
            end
            dgp_pkg::RULE_HALF: begin
               r0.value = $signed(resid(x, {1'b0, w[7:1]} + {1'b0, n[7:1]}));
            end
            dgp_pkg::RULE_CALIC: begin
               if (binary && (x == w)) begin
                  r0.value = 9'sd0;
                  r0.kind  = dgp_pkg::KIND_BINARY;
               end else if (binary && have_s1 && (x == s1)) begin
                  r0.value = 9'sd1;
                  r0.kind  = dgp_pkg::KIND_BINARY;
               end else if (binary) begin
                  // escape marker, then the GAP residual
                  r0.value         = 9'sd2;
                  r0.kind          = dgp_pkg::KIND_ESCAPE;
                  r0.last_of_pixel = 1'b0;
                  r0.end_of_image  = 1'b0;
                  r1.value         = $signed(resid(x, gap_pred));
                  push_two         = 1'b1;
               end else begin
                  r0.value = $signed(resid(x, gap_pred));
               end
            end
            default: begin
               r0.value = $signed(resid(x, w));
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // state update
   // ---------------------------------------------------------------------
   always_comb begin
      column_in   = column_ff;
      row_in      = row_ff;
      fetch_ok_in = fetch_ok_ff || !fetch_ok_ff;
      if (csr_write) begin
         fetch_ok_in = 1'b0;
      end
      if (accept) begin
         column_in = next_col;
         if (last_col) begin
            row_in = end_img ? '0 : row_ff + dgp_pkg::ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= '0;
         row_ff      <= '0;
         w_ff        <= '0;
         ww_ff       <= '0;
         nw_ff       <= '0;
         fetch_ok_ff <= 1'b0;
      end else begin
         column_ff   <= column_in;
         row_ff      <= row_in;
         fetch_ok_ff <= fetch_ok_in;
         if (accept) begin
            w_ff  <= x;
            ww_ff <= w_ff;
            nw_ff <= n;
         end
      end
   end

   // ---------------------------------------------------------------------
   // result queue
   // ---------------------------------------------------------------------
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + (push_two ? dgp_pkg::OUT_PTR_W'(2)
                                           : dgp_pkg::OUT_PTR_W'(1));
         count_in  = count_in + (push_two ? dgp_pkg::OUT_CNT_W'(2)
                                          : dgp_pkg::OUT_CNT_W'(1));
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + dgp_pkg::OUT_PTR_W'(1);
         count_in  = count_in - dgp_pkg::OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= r0;
         if (push_two) begin
            queue_ff[wr_ptr_ff + dgp_pkg::OUT_PTR_W'(1)] <= r1;
         end
      end
   end

   assign rsp_value         = queue_ff[rd_ptr_ff].value;
   assign rsp_kind          = queue_ff[rd_ptr_ff].kind;
   assign rsp_last_of_pixel = queue_ff[rd_ptr_ff].last_of_pixel;
   assign rsp_end_of_image  = queue_ff[rd_ptr_ff].end_of_image;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dgp_pkg::OUT_CNT_W'(dgp_pkg::OUT_DEPTH))
      else $error("result queue overflow");

   // an escape marker at the head always has its residual queued behind it
   a_escape_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == dgp_pkg::KIND_ESCAPE)) |->
      (count_ff >= dgp_pkg::OUT_CNT_W'(2)))
      else $error("escape marker without following residual");

   // escape marker never closes a pixel
   a_escape_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == dgp_pkg::KIND_ESCAPE)) |->
      (!rsp_last_of_pixel && !rsp_end_of_image))
      else $error("escape marker flagged as last result");

   // register write forces a line-store refresh before the next pixel
   a_refetch: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> req_stall)
      else $error("pixel taken before line-store refresh");

endmodule
